[hdl/vtc_pkg.sv]
// vtc_pkg: shared types and constants for the validity time codec
// no dependencies; imported by validity_time_codec

package vtc_pkg;

   localparam int TIME_W   = 31;
   localparam int CODE_W   = 8;
   localparam int OUT_T_W  = 32;
   localparam int UNIT_W   = 16;
   // scaled dividend 16*time + unit - 1 needs 36 bits
   localparam int DIV_W    = TIME_W + 5;
   localparam int STEP_W   = $clog2(DIV_W);
   localparam int MANT_W   = 4;
   localparam int EXP_W    = 4;
   // unit times (16 + mantissa)
   localparam int PROD_W   = UNIT_W + MANT_W + 1;

   localparam logic [CODE_W-1:0] CODE_MAX = 8'hff;
   localparam logic [CODE_W-1:0] CODE_MIN = 8'h00;

   localparam logic FUNC_ENCODE = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   typedef struct packed {
      logic              func;
      logic [TIME_W-1:0] time_in;
      logic [CODE_W-1:0] code_in;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code_out;
      logic [OUT_T_W-1:0] time_out;
   } rsp_type;

endpackage

[hdl/validity_time_codec.sv]
// validity_time_codec: time <-> one-byte validity time converter
// bit-serial restoring divider for encode, serial shifter for decode; uses vtc_pkg

//  channel  ports                             direction  handshake
//  request  start, busy, req_data             in         start && !busy
//  result   rsp_valid, rsp_data               out        one-cycle strobe
//  csr      csr_valid, csr_ready, csr_data    in         csr_valid && csr_ready
//
// encode: a load step, 36 divider steps (one quotient bit per cycle, MSB first),
//   then a finish step; rsp_valid is registered from it
// decode: a load step, b shifts (b = exponent nibble), then the same finish step
// one item is in flight at a time
// reset is synchronous; it clears the control state and loads time_unit = 16
// the receiver cannot stall; csr_ready is low while busy or while start is high

module validity_time_codec (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  vtc_pkg::req_type           req_data,
   output logic                       rsp_valid,
   output vtc_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [vtc_pkg::UNIT_W-1:0] csr_data
);
   import vtc_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [UNIT_W-1:0] unit_ff, unit_in;
   logic              func_ff, func_in;
   logic              zero_ff, zero_in;      // unit was zero at start
   logic [DIV_W-1:0]  div_ff, div_in;        // dividend shifter, decode accumulator
   logic [UNIT_W-1:0] rem_ff, rem_in;        // partial remainder
   logic [STEP_W-1:0] step_ff, step_in;      // bit index / shift count
   logic              found_ff, found_in;    // leading quotient one seen
   logic [STEP_W-1:0] lead_ff, lead_in;      // leading-one position
   logic [MANT_W-1:0] mant_ff, mant_in;
   logic [2:0]        mcnt_ff, mcnt_in;      // mantissa bits taken
   logic              vld_ff, vld_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic [UNIT_W:0]   rem_sh;                // remainder with next dividend bit
   logic [UNIT_W+1:0] diff;
   logic              qbit;
   logic [PROD_W-1:0] prod;
   logic [DIV_W-1:0]  scaled;
   logic [STEP_W-1:0] exp_full;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   // no unit change under an item in flight or one being offered
   assign csr_ready = !busy && !start;
   assign rsp_valid = vld_ff;
   assign rsp_data  = rsp_ff;

   // one restoring division step
   assign rem_sh = {rem_ff, div_ff[DIV_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, unit_ff};
   assign qbit   = !diff[UNIT_W+1];

   // decode product unit * (16 + mantissa), narrow multiplier
   assign prod   = PROD_W'(unit_ff * {1'b1, req_data.code_in[CODE_W-1:EXP_W]});
   // encode dividend 16*time + unit - 1
   assign scaled = DIV_W'({req_data.time_in, 4'b0000}) + DIV_W'(unit_ff - 1'b1);

   assign exp_full = lead_ff - STEP_W'(MANT_W);

   always_comb begin
      state_in = state_ff;
      unit_in  = unit_ff;
      func_in  = func_ff;
      zero_in  = zero_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      found_in = found_ff;
      lead_in  = lead_ff;
      mant_in  = mant_ff;
      mcnt_in  = mcnt_ff;
      vld_in   = 1'b0;
      rsp_in   = rsp_ff;

      // config writes land only while idle
      if (csr_valid && csr_ready) begin
         unit_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in  = req_data.func;
               zero_in  = (unit_ff == '0);
               rem_in   = '0;
               found_in = 1'b0;
               lead_in  = '0;
               mant_in  = '0;
               mcnt_in  = '0;
               if (req_data.func == FUNC_ENCODE) begin
                  div_in   = scaled;
                  step_in  = STEP_W'(DIV_W - 1);
                  state_in = ST_DIV;
               end else begin
                  div_in   = DIV_W'(prod);
                  step_in  = STEP_W'(req_data.code_in[EXP_W-1:0]);
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_DIV: begin
            // quotient bit for position step_ff
            rem_in = qbit ? diff[UNIT_W-1:0] : rem_sh[UNIT_W-1:0];
            div_in = {div_ff[DIV_W-2:0], 1'b0};
            if (!found_ff) begin
               if (qbit) begin
                  found_in = 1'b1;
                  lead_in  = step_ff;
               end
            end else if (mcnt_ff < 3'(MANT_W)) begin
               mant_in = {mant_ff[MANT_W-2:0], qbit};
               mcnt_in = mcnt_ff + 3'd1;
            end
            if (step_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_SHIFT: begin
            if (step_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               div_in  = {div_ff[DIV_W-2:0], 1'b0};
               step_in = step_ff - 1'b1;
            end
         end
         ST_FIN: begin
            vld_in   = 1'b1;
            state_in = ST_IDLE;
            if (func_ff == FUNC_DECODE) begin
               rsp_in.code_out = CODE_MIN;
               rsp_in.time_out = div_ff[DIV_W-1:DIV_W-OUT_T_W];
            end else begin
               rsp_in.time_out = '0;
               if (zero_ff) begin
                  rsp_in.code_out = CODE_MAX;
               end else if (!found_ff || lead_ff < STEP_W'(MANT_W)) begin
                  rsp_in.code_out = CODE_MIN;       // too small
               end else if (exp_full > STEP_W'(15)) begin
                  rsp_in.code_out = CODE_MAX;       // too large
               end else begin
                  rsp_in.code_out = {mant_ff, exp_full[EXP_W-1:0]};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         unit_ff  <= UNIT_W'(16);
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         unit_ff  <= unit_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      zero_ff  <= zero_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      found_ff <= found_in;
      lead_ff  <= lead_in;
      mant_ff  <= mant_in;
      mcnt_ff  <= mcnt_in;
      rsp_ff   <= rsp_in;
   end

   // result strobe only fires as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // an accepted item always occupies the sequencer next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start");

   // the unused result field is zero
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.code_out == CODE_MIN || rsp_data.time_out == '0))
      else $error("both result fields nonzero");

   // partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && !zero_ff) |-> (rem_ff < unit_ff))
      else $error("divider remainder out of range");

endmodule

[tb/testbench.sv]
// testbench: self-checking bench for validity_time_codec (time <-> one-byte validity code)
// depends on vtc_pkg for the item structs and codes; drives the block through its ports only

module testbench;
   import vtc_pkg::*;

   // 16 is the mantissa bias: a code stands for unit * (16 + a) * 2^b / 16
   localparam int unsigned MANT_BIAS = 16;
   localparam logic [UNIT_W-1:0] RESET_UNIT = UNIT_W'(16);
   localparam logic [UNIT_W-1:0] UNIT_MAX = '1;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   // covers the longest encode or decode; leave some margin for stray results
   localparam int SETTLE_CYCLES = 45;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 215;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [UNIT_W-1:0]   csr_data;

   // one outstanding conversion: the item, the unit it saw and what must come back
   typedef struct {
      req_type           item;
      logic [UNIT_W-1:0] unit_used;
      rsp_type           result;
   } conversion_type;

   conversion_type    pending_conversions[$];
   logic [UNIT_W-1:0] time_unit_model;
   int                mismatch_count;
   bit                steady_flow;

   validity_time_codec dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit: the slowest correct run stays well below a fifth of this
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------
   // conversion predictor
   // ---------------------------------------------------------------------

   // encode: rel = ceil(16 * time / unit), code = {four bits under the leading one, lead - 4}
   // decode: floor(unit * ((16 + a) << b) / 16)
   function automatic rsp_type predict_conversion(req_type item, logic [UNIT_W-1:0] unit);
      rsp_type            res;
      logic [63:0]        rel;
      logic [63:0]        mant;
      logic [63:0]        scaled;
      int                 lead;
      logic [MANT_W-1:0]  dec_mant;
      logic [EXP_W-1:0]   dec_exp;
      res = '0;
      if (item.func == FUNC_ENCODE) begin
         if (unit == '0) begin
            // zero unit counts as an endless time
            res.code_out = CODE_MAX;
         end else begin
            rel = (64'(item.time_in) * MANT_BIAS + 64'(unit) - 64'd1) / 64'(unit);
            lead = 0;
            for (int i = 0; i < 64; i++)
               if (rel[i])
                  lead = i;
            if (lead < MANT_W) begin
               // below the smallest code
               res.code_out = CODE_MIN;
            end else if (lead - MANT_W > 15) begin
               // exponent overflows the nibble
               res.code_out = CODE_MAX;
            end else begin
               mant = (rel - (64'd1 << lead)) >> (lead - MANT_W);
               res.code_out = {mant[MANT_W-1:0], EXP_W'(lead - MANT_W)};
            end
         end
      end else begin
         dec_mant = item.code_in[CODE_W-1 -: MANT_W];
         dec_exp = item.code_in[EXP_W-1:0];
         scaled = 64'(unit) * ((64'(MANT_BIAS) + 64'(dec_mant)) << dec_exp);
         res.time_out = OUT_T_W'(scaled / MANT_BIAS);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // shared driving and checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // mostly no gap, some short ones, a few long; none at all in steady phases
   function automatic int pick_gap();
      int roll;
      if (steady_flow)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // start stays high across back-to-back items; it only drops for a gap or a drain
   task automatic send_item(input req_type item);
      conversion_type entry;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      entry.item = item;
      entry.unit_used = time_unit_model;
      entry.result = predict_conversion(item, time_unit_model);
      pending_conversions.push_back(entry);
   endtask

   // sender holds off until every outstanding item has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_conversions.size() != 0) @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_time_unit(input logic [UNIT_W-1:0] value);
      repeat (pick_gap()) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      time_unit_model = value;
   endtask

   function automatic req_type encode_item(input logic [TIME_W-1:0] t);
      req_type item;
      item.func = FUNC_ENCODE;
      item.time_in = t;
      // unused field carries junk
      item.code_in = CODE_W'($urandom);
      return item;
   endfunction

   function automatic req_type decode_item(input logic [CODE_W-1:0] code);
      req_type item;
      item.func = FUNC_DECODE;
      item.time_in = TIME_W'($urandom);
      item.code_in = code;
      return item;
   endfunction

   // every strobe is checked against the oldest outstanding item
   always @(posedge clock) begin : check_results
      conversion_type want;
      if (!reset && rsp_valid) begin
         if (pending_conversions.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = pending_conversions.pop_front();
            if (rsp_data.code_out !== want.result.code_out)
               report_mismatch($sformatf(
                  "code_out %02h, want %02h (func %0b time %0d code %02h unit %0d)",
                  rsp_data.code_out, want.result.code_out, want.item.func,
                  want.item.time_in, want.item.code_in, want.unit_used));
            if (rsp_data.time_out !== want.result.time_out)
               report_mismatch($sformatf(
                  "time_out %0d, want %0d (func %0b time %0d code %02h unit %0d)",
                  rsp_data.time_out, want.result.time_out, want.item.func,
                  want.item.time_in, want.item.code_in, want.unit_used));
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // unit left at its reset value: too small, smallest codes, largest exponent, overflow
   task automatic test_reset_unit_encode();
      send_item(encode_item(TIME_W'(0)));
      send_item(encode_item(TIME_W'(15)));
      send_item(encode_item(TIME_W'(16)));
      send_item(encode_item(TIME_W'(17)));
      send_item(encode_item(31'h000f_ffff));
      send_item(encode_item(31'h0010_0000));
      send_item(encode_item(TIME_MAX));
   endtask

   // nibble extremes of the code byte
   task automatic test_reset_unit_decode();
      send_item(decode_item(8'h00));
      send_item(decode_item(8'hff));
      send_item(decode_item(8'h0f));
      send_item(decode_item(8'hf0));
   endtask

   // smallest and largest unit, then the largest decoded time
   task automatic test_unit_extremes();
      drain_results();
      write_time_unit(UNIT_W'(1));
      send_item(encode_item(TIME_MAX));
      send_item(encode_item(TIME_W'(1)));
      send_item(decode_item(8'hff));
      drain_results();
      write_time_unit(UNIT_MAX);
      send_item(encode_item(TIME_MAX));
      send_item(encode_item(TIME_W'(0)));
      send_item(decode_item(8'hff));
   endtask

   // zero unit: encode saturates, decode gives zero
   task automatic test_zero_unit();
      drain_results();
      write_time_unit('0);
      send_item(encode_item(31'd12345));
      send_item(decode_item(8'ha7));
   endtask

   // random items over several unit settings, some phases without random gaps
   task automatic test_random_units();
      logic [UNIT_W-1:0] unit;
      logic [63:0]       near;
      logic [TIME_W-1:0] t;
      req_type           item;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case ($urandom_range(0, 3))
            0: unit = UNIT_W'($urandom_range(1, 32));
            1: unit = UNIT_W'(1) << $urandom_range(0, UNIT_W - 1);
            2: unit = UNIT_W'($urandom_range(1, 65535));
            default: unit = $urandom_range(0, 1) ? UNIT_MAX : UNIT_W'(1);
         endcase
         drain_results();
         write_time_unit(unit);
         steady_flow = (phase == 2 || phase == 5);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // spread times over all magnitudes, with extra weight near code steps
            case ($urandom_range(0, 3))
               0: t = TIME_W'($urandom);
               1: t = TIME_W'($urandom) >> $urandom_range(0, TIME_W - 1);
               2: begin
                  near = (64'(unit) << $urandom_range(0, 24)) >> 4;
                  near = near + 64'($urandom_range(0, 4)) - 64'd2;
                  if (near > 64'(TIME_MAX))
                     near = 64'(TIME_MAX);
                  t = TIME_W'(near);
               end
               default: t = TIME_W'($urandom_range(0, 2 * int'(unit)));
            endcase
            if ($urandom_range(0, 1))
               item = encode_item(t);
            else
               item = decode_item(CODE_W'($urandom));
            send_item(item);
            // now and then the sender waits for everything to come back
            if ($urandom_range(0, 99) < 2)
               drain_results();
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      mismatch_count = 0;
      steady_flow = 1'b0;
      time_unit_model = RESET_UNIT;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_unit_encode();
      test_reset_unit_decode();
      test_unit_extremes();
      test_zero_unit();
      test_random_units();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_conversions.size() != 0)
         report_mismatch("items still outstanding at the end");
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
